// File: src/eqfs_pkg.sv
// shared types and constants for the eight queens fixed search unit
`default_nettype none
package eqfs_pkg;

	localparam int BOARD_SIZE = 8;
	localparam int RowW       = $clog2(BOARD_SIZE);
	localparam int ColW       = 3;
	localparam int MaskW      = 8;
	localparam int FixColW    = 24;
	localparam int CfgIdxW    = 1;
	localparam int CfgDataW   = 24;

	localparam logic [CfgIdxW-1:0] REG_FIXED_ROW_MASK = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_FIXED_COLUMNS  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;       // load identity order, start a search
		logic step;       // advance to the next lexicographic order
		logic clr_row;    // clear the result row counter
		logic emit;       // put out the row at the counter
		logic emit_fail;  // put out the single no-placement result
	} dp_cmd_t;

	typedef struct packed {
		logic ok;         // current order satisfies every constraint
		logic more;       // a next order exists before wrapping
		logic last_row;   // row counter is on the final row
	} dp_stat_t;

endpackage
`default_nettype wire

// File: src/eqfs_dp.sv
// datapath: configuration, permutation register, checker, next-order logic, result registers
`default_nettype none
module eqfs_dp import eqfs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	input  wire dp_cmd_t             cmd,
	output dp_stat_t                 stat,
	output logic                     valid,
	output logic [2:0]               row,
	output logic [2:0]               column,
	output logic                     found,
	output logic                     last
);

	logic [MaskW-1:0]   mask_q;
	logic [FixColW-1:0] fixcol_q;
	logic [ColW-1:0]    perm_q [BOARD_SIZE];
	logic [ColW-1:0]    perm_nxt [BOARD_SIZE];
	logic [RowW-1:0]    row_cnt_q;
	logic               ok;
	logic               piv_found;
	logic [RowW-1:0]    piv;
	logic [RowW-1:0]    succ;

	logic               valid_q;
	logic [2:0]         row_q;
	logic [2:0]         column_q;
	logic               found_q;
	logic               last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			fixcol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIXED_ROW_MASK: mask_q   <= cfg_wdata[MaskW-1:0];
				REG_FIXED_COLUMNS:  fixcol_q <= cfg_wdata[FixColW-1:0];
				default: ;
			endcase
		end
	end

	// fixed rows and diagonal check of the current order
	always_comb begin
		logic [ColW-1:0] dc;
		ok = 1'b1;
		for (int i = 0; i < BOARD_SIZE; i++) begin
			if (mask_q[i] && (perm_q[i] != fixcol_q[3*i +: 3]))
				ok = 1'b0;
		end
		for (int i = 0; i < BOARD_SIZE; i++) begin
			for (int j = i + 1; j < BOARD_SIZE; j++) begin
				dc = (perm_q[i] > perm_q[j]) ? perm_q[i] - perm_q[j]
				                             : perm_q[j] - perm_q[i];
				if (dc == ColW'(j - i))
					ok = 1'b0;
			end
		end
	end

	// next lexicographic order: pivot, successor, swap and reversed tail
	always_comb begin
		logic [RowW:0] src;
		logic [ColW-1:0] pv;
		piv_found = 1'b0;
		piv       = '0;
		for (int k = 0; k < BOARD_SIZE - 1; k++) begin
			if (perm_q[k] < perm_q[k+1]) begin
				piv_found = 1'b1;
				piv       = RowW'(k);
			end
		end
		pv   = perm_q[piv];
		succ = '0;
		for (int k = 0; k < BOARD_SIZE; k++) begin
			if ((RowW'(k) > piv) && (perm_q[k] > pv))
				succ = RowW'(k);
		end
		for (int k = 0; k < BOARD_SIZE; k++) begin
			src = (RowW+1)'(BOARD_SIZE) + {1'b0, piv} - (RowW+1)'(k);
			if (!piv_found) begin
				perm_nxt[k] = perm_q[BOARD_SIZE-1-k];
			end else if (RowW'(k) < piv) begin
				perm_nxt[k] = perm_q[k];
			end else if (RowW'(k) == piv) begin
				perm_nxt[k] = perm_q[succ];
			end else if (src[RowW-1:0] == succ) begin
				perm_nxt[k] = pv;
			end else begin
				perm_nxt[k] = perm_q[src[RowW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < BOARD_SIZE; k++) begin
			if (cmd.load)
				perm_q[k] <= ColW'(k);
			else if (cmd.step)
				perm_q[k] <= perm_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_cnt_q <= '0;
		else if (cmd.clr_row)
			row_cnt_q <= '0;
		else if (cmd.emit)
			row_cnt_q <= row_cnt_q + 1'b1;
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.emit | cmd.emit_fail;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_q    <= 3'(row_cnt_q);
			column_q <= 3'(perm_q[row_cnt_q]);
			found_q  <= 1'b1;
			last_q   <= (row_cnt_q == RowW'(BOARD_SIZE - 1));
		end else if (cmd.emit_fail) begin
			row_q    <= '0;
			column_q <= '0;
			found_q  <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign stat.ok       = ok;
	assign stat.more     = piv_found;
	assign stat.last_row = (row_cnt_q == RowW'(BOARD_SIZE - 1));

	assign valid  = valid_q;
	assign row    = row_q;
	assign column = column_q;
	assign found  = found_q;
	assign last   = last_q;

endmodule
`default_nettype wire

// File: src/eqfs_ctrl.sv
// controller state machine for the search and result sequence
`default_nettype none
module eqfs_ctrl import eqfs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     start_req,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && start_req) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (stat.ok) begin
					cmd.clr_row = 1'b1;
					state_nxt   = ST_EMIT;
				end else if (stat.more) begin
					cmd.step = 1'b1;
				end else begin
					// wrapped past the last order: report no placement
					cmd.step      = 1'b1;
					cmd.emit_fail = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.last_row)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/eight_queens_fixed_search_unit.sv
// top level of the eight queens search with pre-placed queens
// a search checks k orders (1..40320) before its first result beat, found or not
// one order is checked per cycle by the single checker and next-order unit in the datapath
// a found placement gives 8 result beats on consecutive cycles, none found gives one beat
// busy is high while searching or emitting, low when the last beat is valid; results cannot stall
// arst_n clears the controller, configuration and result strobe; the board is reloaded per start
`default_nettype none
module eight_queens_fixed_search_unit import eqfs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command channel
	input  wire logic                start,
	input  wire logic                start_req,
	output logic                     busy,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	// result channel, one beat per cycle of valid
	output logic                     valid,
	output logic [2:0]               row,
	output logic [2:0]               column,
	output logic                     found,
	output logic                     last
);

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller: idle, search one order per cycle, then stream the rows or report no placement
	eqfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_req (start_req),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	// datapath: permutation register, constraint checker, next-order logic
	eqfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.valid     (valid),
		.row       (row),
		.column    (column),
		.found     (found),
		.last      (last)
	);

endmodule
`default_nettype wire
